// File: design/crcfm_pkg.sv
// shared types, status codes and the byte-wide crc-16 update for the framed message checker
// no dependencies; imported by every module of the block
package crcfm_pkg;

    localparam logic [7:0]  START_BYTE = 8'h01;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  MIN_LENGTH = 8'd6;
    localparam logic [7:0]  LAST_POS   = 8'd255;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_START = 2'd1,
        STATUS_BAD_LEN   = 2'd2,
        STATUS_BAD_CRC   = 2'd3
    } crcfm_status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } crcfm_kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } crcfm_beat_t;

    typedef struct packed {
        logic          valid;
        crcfm_kind_t   kind;
        logic [7:0]    payload;
        crcfm_status_t status;
        logic [7:0]    msg_type;
        logic [7:0]    option;
        logic [7:0]    count;
    } crcfm_result_t;

    // reflected-input byte update, msb-first shift
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  r;
        logic [15:0] x;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = b[i];
        end
        x = crc ^ {r, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (x[15])
            begin
                x = {x[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                x = {x[14:0], 1'b0};
            end
        end
        return x;
    endfunction

endpackage

// File: design/crcfm_in_reg.sv
// input register for received bytes, stalls only while its beat cannot move on
// depends on crcfm_pkg
module crcfm_in_reg
    import crcfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        advance,
    output crcfm_beat_t beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    assign item_stall = valid_reg && !advance;
    assign valid_next = item_stall ? valid_reg : item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            data_reg <= data_byte;
            last_reg <= frame_end;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;
    assign beat.last  = last_reg;

endmodule

// File: design/crcfm_frame_ctrl.sv
// frame tracking state, crc accumulation and per-beat result decision
// depends on crcfm_pkg
module crcfm_frame_ctrl
    import crcfm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  crcfm_beat_t   beat,
    input  logic          advance,
    output crcfm_result_t res
);

    logic [7:0]  pos_reg,  pos_next;
    logic        ovf_reg,  ovf_next;
    logic [7:0]  len_reg,  len_next;
    logic        sok_reg,  sok_next;
    logic [15:0] crc_reg,  crc_next;
    logic [7:0]  crcl_reg, crcl_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  opt_reg,  opt_next;

    logic          step;
    logic [7:0]  b;
    logic [7:0]  dl;
    logic        sok;
    logic [7:0]  typ;
    logic [7:0]  opt;
    logic [8:0]  pos_p2;
    logic [8:0]  pos_p1;
    logic        before_crc;
    logic        feed;
    crcfm_status_t status;

    assign step   = beat.valid && advance;
    assign b      = beat.data;
    assign dl     = (!ovf_reg && pos_reg == 8'd1) ? b : len_reg;
    assign sok    = (!ovf_reg && pos_reg == 8'd0) ? (b == START_BYTE) : sok_reg;
    assign typ    = (!ovf_reg && pos_reg == 8'd2) ? b : type_reg;
    assign opt    = (!ovf_reg && pos_reg == 8'd3) ? b : opt_reg;
    assign pos_p2 = {1'b0, pos_reg} + 9'd2;
    assign pos_p1 = {1'b0, pos_reg} + 9'd1;
    assign before_crc = pos_p2 < {1'b0, dl};
    assign feed   = !ovf_reg && (pos_reg < 8'd2 || before_crc);

    always_comb
    begin
        if (!sok)
        begin
            status = STATUS_BAD_START;
        end
        else if (ovf_reg || pos_p1 != {1'b0, dl} || dl < MIN_LENGTH)
        begin
            status = STATUS_BAD_LEN;
        end
        else if (crc_reg[7:0] != crcl_reg || crc_reg[15:8] != b)
        begin
            status = STATUS_BAD_CRC;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_comb
    begin
        res          = '0;
        res.kind     = KIND_PAYLOAD;
        res.status   = STATUS_OK;
        pos_next     = pos_reg;
        ovf_next     = ovf_reg;
        len_next     = len_reg;
        sok_next     = sok_reg;
        crc_next     = crc_reg;
        crcl_next    = crcl_reg;
        type_next    = type_reg;
        opt_next     = opt_reg;
        if (step)
        begin
            if (beat.last)
            begin
                res.valid  = 1'b1;
                res.kind   = KIND_REPORT;
                res.status = status;
                if (status == STATUS_OK)
                begin
                    res.msg_type = typ;
                    res.option   = opt;
                    res.count    = dl - MIN_LENGTH;
                end
                pos_next  = '0;
                ovf_next  = 1'b0;
                len_next  = '0;
                sok_next  = 1'b0;
                crc_next  = CRC_INIT;
                crcl_next = '0;
                type_next = '0;
                opt_next  = '0;
            end
            else
            begin
                if (feed)
                begin
                    crc_next = crc_feed(crc_reg, b);
                end
                if (!ovf_reg && pos_reg >= 8'd2 && pos_p2 == {1'b0, dl})
                begin
                    crcl_next = b;
                end
                len_next  = dl;
                sok_next  = sok;
                type_next = typ;
                opt_next  = opt;
                if (ovf_reg || pos_reg == LAST_POS)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_p1[7:0];
                end
                if (sok && !ovf_reg && pos_reg >= 8'd4 && before_crc)
                begin
                    res.valid   = 1'b1;
                    res.payload = b;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            ovf_reg  <= 1'b0;
            len_reg  <= '0;
            sok_reg  <= 1'b0;
            crc_reg  <= CRC_INIT;
            crcl_reg <= '0;
            type_reg <= '0;
            opt_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            ovf_reg  <= ovf_next;
            len_reg  <= len_next;
            sok_reg  <= sok_next;
            crc_reg  <= crc_next;
            crcl_reg <= crcl_next;
            type_reg <= type_next;
            opt_reg  <= opt_next;
        end
    end

endmodule

// File: design/crcfm_out_reg.sv
// result register holding one beat until the receiver takes it
// depends on crcfm_pkg
module crcfm_out_reg
    import crcfm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  crcfm_result_t res,
    output logic          advance,
    output logic          result_valid,
    input  logic          result_stall,
    output logic          result_kind,
    output logic [7:0]    payload_byte,
    output logic [1:0]    frame_status,
    output logic [7:0]    frame_type,
    output logic [7:0]    frame_option,
    output logic [7:0]    payload_count
);

    logic          valid_reg;
    logic          valid_next;
    crcfm_result_t data_reg;

    assign advance    = !valid_reg || !result_stall;
    assign valid_next = advance ? res.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            data_reg <= res;
        end
    end

    assign result_valid  = valid_reg;
    assign result_kind   = data_reg.kind;
    assign payload_byte  = data_reg.payload;
    assign frame_status  = data_reg.status;
    assign frame_type    = data_reg.msg_type;
    assign frame_option  = data_reg.option;
    assign payload_count = data_reg.count;

endmodule

// File: design/crc_framed_message_checker_core.sv
// framed message checker: start, length and crc-16 check with payload pass-through
// input beat: data_byte plus frame_end marking the last byte of a frame
// result beat: either one passed-on payload byte or one end-of-frame report
// both channels use valid/stall; a beat moves when valid is high and stall low
// frame: 0x01, total length, type, option, payload, crc-16 low byte then high byte
// payload bytes are passed on before the frame is checked; drop them on a bad report
// each result passes through the input register and then the result register
// throughput: one byte per cycle while the receiver does not stall, set by the byte-wide
// crc update between the input register and the result register
// bytes that cause no result (header, crc low byte) pass through and produce nothing
// receiver stall holds the result register; the input register keeps one more
// beat and then item_stall rises, so nothing is lost
// reset clears all frame state; crc starts at 0xffff, the next byte is a start byte
// depends on crcfm_pkg, crcfm_in_reg, crcfm_frame_ctrl, crcfm_out_reg
module crc_framed_message_checker_core
    import crcfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] data_byte,
    input  logic       frame_end,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       result_kind,
    output logic [7:0] payload_byte,
    output logic [1:0] frame_status,
    output logic [7:0] frame_type,
    output logic [7:0] frame_option,
    output logic [7:0] payload_count
);

    crcfm_beat_t   beat;
    crcfm_result_t res;
    logic          advance;

    crcfm_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .frame_end  (frame_end),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .advance    (advance),
        .beat       (beat)
    );

    crcfm_frame_ctrl u_frame_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .advance (advance),
        .res     (res)
    );

    crcfm_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .advance       (advance),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .frame_status  (frame_status),
        .frame_type    (frame_type),
        .frame_option  (frame_option),
        .payload_count (payload_count)
    );

    a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> beat.valid)
        else $error("accepted beat not held in input register");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_PAYLOAD) |->
        (frame_status == STATUS_OK && frame_type == 8'd0 &&
         frame_option == 8'd0 && payload_count == 8'd0))
        else $error("payload beat carries report fields");

    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_REPORT) |-> payload_byte == 8'd0)
        else $error("report beat carries payload byte");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_REPORT && frame_status == STATUS_OK) |->
        payload_count <= 8'd249)
        else $error("payload count out of range on good frame");

endmodule

// File: bench/tb_crc_framed_message_checker_core.sv
// testbench for crc_framed_message_checker_core: frames of bytes in, payload beats and
// end-of-frame reports out, each checked against a cycle-free predictor of the deframer
// depends on crcfm_pkg and crc_framed_message_checker_core
`timescale 1ns / 1ps

module tb_crc_framed_message_checker_core;
    import crcfm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        crcfm_kind_t   kind;
        logic [7:0]    payload;
        crcfm_status_t status;
        logic [7:0]    msg_type;
        logic [7:0]    option;
        logic [7:0]    count;
    } deframe_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic [7:0] data_byte = 8'h00;
    logic       frame_end = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;
    logic [7:0] frame_type;
    logic [7:0] frame_option;
    logic [7:0] payload_count;

    // predictor state of the deframer
    logic [7:0]  pos_q = 8'h00;
    logic        ovf_q = 1'b0;
    logic [7:0]  len_q = 8'h00;
    logic        start_q = 1'b0;
    logic [15:0] crc_q = CRC_INIT;
    logic [7:0]  crc_lo_q = 8'h00;
    logic [7:0]  type_q = 8'h00;
    logic [7:0]  opt_q = 8'h00;

    deframe_out_t deframed_q[$];
    logic [7:0]   frame_bytes[$];

    logic        idle_on = 1'b1;
    int unsigned bytes_sent = 0;
    int unsigned fails = 0;
    int unsigned cycles = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned burst_left = 0;

    crc_framed_message_checker_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .data_byte     (data_byte),
        .frame_end     (frame_end),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .frame_status  (frame_status),
        .frame_type    (frame_type),
        .frame_option  (frame_option),
        .payload_count (payload_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // lsb of the byte enters first, same as shifting in the reflected byte msb first
    function automatic logic [15:0] crc16_reflected_step(input logic [15:0] c,
                                                         input logic [7:0] b);
        logic [15:0] x;
        x = c;
        for (int i = 0; i < 8; i++)
        begin
            x = {x[14:0], 1'b0} ^ ((x[15] ^ b[i]) ? CRC_POLY : 16'h0000);
        end
        return x;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic last);
        int           p;
        int           dl;
        logic         ov;
        logic         sok;
        logic         feed;
        logic [7:0]   ty;
        logic [7:0]   op;
        deframe_out_t r;
        p = pos_q;
        ov = ovf_q;
        dl = (!ov && p == 1) ? int'(b) : int'(len_q);
        sok = (!ov && p == 0) ? (b == START_BYTE) : start_q;
        ty = (!ov && p == 2) ? b : type_q;
        op = (!ov && p == 3) ? b : opt_q;
        feed = !ov && (p < 2 || p + 2 < dl);
        r.kind = KIND_PAYLOAD;
        r.payload = 8'h00;
        r.status = STATUS_OK;
        r.msg_type = 8'h00;
        r.option = 8'h00;
        r.count = 8'h00;
        if (last)
        begin
            r.kind = KIND_REPORT;
            if (!sok)
                r.status = STATUS_BAD_START;
            else if (ov || p + 1 != dl || dl < int'(MIN_LENGTH))
                r.status = STATUS_BAD_LEN;
            else if (crc_q[7:0] != crc_lo_q || crc_q[15:8] != b)
                r.status = STATUS_BAD_CRC;
            else
            begin
                r.msg_type = ty;
                r.option = op;
                r.count = 8'(dl - int'(MIN_LENGTH));
            end
            deframed_q.push_back(r);
            pos_q = 8'h00;
            ovf_q = 1'b0;
            len_q = 8'h00;
            start_q = 1'b0;
            crc_q = CRC_INIT;
            crc_lo_q = 8'h00;
            type_q = 8'h00;
            opt_q = 8'h00;
            return;
        end
        if (feed)
            crc_q = crc16_reflected_step(crc_q, b);
        if (!ov && p >= 2 && p + 2 == dl)
            crc_lo_q = b;
        len_q = 8'(dl);
        start_q = sok;
        type_q = ty;
        opt_q = op;
        if (ov || p == 255)
            ovf_q = 1'b1;
        else
            pos_q = 8'(p + 1);
        if (sok && !ov && p >= 4 && p + 2 < dl)
        begin
            r.payload = b;
            deframed_q.push_back(r);
        end
    endfunction

    // receiver: random stall bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left <= burst_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 5) == 0)
                burst_left <= $urandom_range(1, 11);
        end
    end

    always @(posedge clk)
    begin
        deframe_out_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (deframed_q.size() == 0)
            begin
                $error("result beat with nothing pending: kind %0d", result_kind);
                fails++;
            end
            else
            begin
                e = deframed_q.pop_front();
                if (result_kind !== e.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", e.kind, result_kind);
                    fails++;
                end
                if (payload_byte !== e.payload)
                begin
                    $error("payload_byte: expected %0h, got %0h", e.payload, payload_byte);
                    fails++;
                end
                if (frame_status !== e.status)
                begin
                    $error("frame_status: expected %0d, got %0d", e.status, frame_status);
                    fails++;
                end
                if (frame_type !== e.msg_type)
                begin
                    $error("frame_type: expected %0h, got %0h", e.msg_type, frame_type);
                    fails++;
                end
                if (frame_option !== e.option)
                begin
                    $error("frame_option: expected %0h, got %0h", e.option, frame_option);
                    fails++;
                end
                if (payload_count !== e.count)
                begin
                    $error("payload_count: expected %0d, got %0d", e.count, payload_count);
                    fails++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        data_byte <= b;
        frame_end <= last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        deframe_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // well-formed frame with n random payload bytes and a correct crc
    task automatic make_frame(input logic [7:0] ty, input logic [7:0] op, input int n);
        logic [15:0] c;
        frame_bytes = {START_BYTE, 8'(n + 6), ty, op};
        repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
        c = CRC_INIT;
        foreach (frame_bytes[i])
        begin
            c = crc16_reflected_step(c, frame_bytes[i]);
        end
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endtask

    // header and crc bytes give no result, so allow the pipeline to empty after the queue
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_directed();
        make_frame(8'hFF, 8'h00, 0);
        send_frame();
        // wrong start wins over an early end
        frame_bytes = {8'h00, 8'h06};
        send_frame();
        // ends before the length byte
        frame_bytes = {START_BYTE};
        send_frame();
        // length under six, otherwise consistent
        frame_bytes = {START_BYTE, 8'h05, 8'h00, 8'hFF, 8'hAA};
        send_frame();
        make_frame(8'h00, 8'hFF, 1);
        frame_bytes[frame_bytes.size() - 1] ^= 8'h80;
        send_frame();
        // ends where a payload byte would be
        make_frame(8'h12, 8'h34, 4);
        frame_bytes = frame_bytes[0:5];
        send_frame();
        wait_drained();
    endtask

    task automatic test_long_frames();
        make_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 249);
        send_frame();
        // runs past 255 bytes
        make_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 249);
        repeat (2) frame_bytes.push_back(8'($urandom_range(0, 255)));
        send_frame();
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_req++;
        make_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 30);
        send_frame();
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned k;
        make_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 14));
        pick = $urandom_range(0, 9);
        if (pick == 6)
            frame_bytes[0] ^= 8'($urandom_range(1, 255));
        else if (pick == 7)
            frame_bytes[1] ^= 8'($urandom_range(1, 255));
        else if (pick == 8)
        begin
            k = $urandom_range(2, frame_bytes.size() - 1);
            frame_bytes[k] ^= 8'(1 << $urandom_range(0, 7));
        end
        else if (pick == 9)
        begin
            case ($urandom_range(0, 2))
                0: frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
                1: repeat ($urandom_range(1, 5)) frame_bytes.push_back(8'($urandom_range(0, 255)));
                default:
                begin
                    frame_bytes = {};
                    repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        send_frame();
    endtask

    task automatic test_random();
        int unsigned stop_at;
        stop_at = bytes_sent + 140;
        while (bytes_sent < stop_at)
            random_frame();
        wait_drained();
    endtask

    task automatic test_steady();
        int unsigned stop_at;
        idle_on = 1'b0;
        stop_at = bytes_sent + 50;
        while (bytes_sent < stop_at)
            random_frame();
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_frames();
        test_backpressure();
        test_random();
        test_steady();
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
design/crcfm_pkg.sv
design/crcfm_in_reg.sv
design/crcfm_frame_ctrl.sv
design/crcfm_out_reg.sv
design/crc_framed_message_checker_core.sv
bench/tb_crc_framed_message_checker_core.sv
